[src/rtu_pkg.sv]
// Shared types, codes and the CRC-16 byte update for the RTU frame receiver.
package rtu_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_TICK     = 2'd1,
		KIND_TX_BEGIN = 2'd2,
		KIND_TX_END   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		VERDICT_OK      = 2'd0,
		VERDICT_CRC_ERR = 2'd1,
		VERDICT_SHORT   = 2'd2,
		VERDICT_NOISE   = 2'd3
	} verdict_t;

	localparam logic RES_BYTE    = 1'b0;
	localparam logic RES_VERDICT = 1'b1;

	localparam logic REG_GAP_RESTART = 1'b0;
	localparam logic REG_FRAME_END   = 1'b1;

	localparam logic [15:0] GAP_RESTART_RESET = 16'd750;
	localparam logic [15:0] FRAME_END_RESET   = 16'd1750;
	localparam logic [15:0] CRC_PRESET        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [15:0] SILENCE_MAX       = 16'hFFFF;
	localparam int unsigned MIN_FRAME         = 4;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] rx_byte;
		logic [3:0] line_errors;
	} item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] byte_value;
		logic [7:0] byte_position;
		verdict_t   verdict;
		logic [7:0] slave_address;
		logic [7:0] func_code;
		logic [7:0] payload_length;
	} result_t;

	typedef struct packed {
		logic [15:0] gap_restart_ticks;
		logic [15:0] frame_end_ticks;
	} cfg_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[src/rtu_frame_receiver_top.sv]
// Top level of the Modbus RTU frame receiver.
// Input channel (in_valid/in_ready) carries one word per UART byte, microsecond
// tick or transmit begin/end mark. Output channel (out_valid/out_ready) carries
// forwarded frame bytes with their position and a verdict for each frame that
// reaches the frame-end silence. Thresholds for frame restart and frame end
// are set over the APB port, which must be written only while the block is
// idle; the block does not enforce this. pready is always high. A word is
// captured in the input register, evaluated against the frame state and
// placed in the result register. One word is accepted every cycle while
// results drain; the CRC update is an unrolled eight-step byte fold.
// When the consumer stalls, the held result blocks the input register, and
// in_ready drops once that register is also full.
// Reset loads the default thresholds, empties both registers and clears the
// frame state, the silence count and the transmit flag.
module rtu_frame_receiver_top
	import rtu_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  rx_byte,
	input  logic [3:0]  line_errors,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  byte_value,
	output logic [7:0]  byte_position,
	output logic [1:0]  verdict,
	output logic [7:0]  slave_address,
	output logic [7:0]  func_code,
	output logic [7:0]  payload_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    free;
	logic    emit;
	result_t result_d;
	result_t result_q;
	cfg_t    cfg;

	assign advance  = valid_s1 && free;
	assign in_ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind        <= kind_t'(kind);
			item_s1.rx_byte     <= rx_byte;
			item_s1.line_errors <= line_errors;
		end
	end

	rtu_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtu_frame_core #(
		.MAX_FRAME (MAX_FRAME)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.emit    (emit),
		.result  (result_d)
	);

	rtu_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.emit      (emit),
		.result_in (result_d),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (free),
		.result_q  (result_q)
	);

	assign result_kind    = result_q.result_kind;
	assign byte_value     = result_q.byte_value;
	assign byte_position  = result_q.byte_position;
	assign verdict        = result_q.verdict;
	assign slave_address  = result_q.slave_address;
	assign func_code      = result_q.func_code;
	assign payload_length = result_q.payload_length;

endmodule

[src/rtu_cfg_regs.sv]
// APB register block holding the two silence thresholds.
module rtu_cfg_regs
	import rtu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [15:0] gap_q;
	logic [15:0] end_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_RESTART_RESET;
			end_q <= FRAME_END_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_GAP_RESTART) begin
				gap_q <= pwdata[15:0];
			end else begin
				end_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_GAP_RESTART) begin
			prdata = {16'h0000, gap_q};
		end else begin
			prdata = {16'h0000, end_q};
		end
	end

	assign cfg.gap_restart_ticks = gap_q;
	assign cfg.frame_end_ticks   = end_q;

endmodule

[src/rtu_frame_core.sv]
// Frame state and the per-word update that yields forwarded bytes and verdicts.
module rtu_frame_core
	import rtu_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  cfg_t    cfg,
	output logic    emit,
	output result_t result
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

	logic [CNT_W-1:0] count_q, count_d;
	logic [15:0]      silence_q, silence_d;
	logic [15:0]      crc_q, crc_d;
	logic             nz_q, nz_d;
	logic             tx_q, tx_d;
	logic [7:0]       addr_q, addr_d;
	logic [7:0]       func_q, func_d;

	logic [CNT_W-1:0] cnt_base;
	logic [15:0]      crc_base;
	logic             nz_base;
	logic [7:0]       addr_base;
	logic [7:0]       func_base;
	logic [CNT_W-1:0] cnt_next;
	logic [15:0]      sil_inc;
	logic [CNT_W+7:0] pos_ext;
	logic [CNT_W+7:0] pl_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			silence_q <= '0;
			crc_q     <= CRC_PRESET;
			nz_q      <= 1'b0;
			tx_q      <= 1'b0;
			addr_q    <= '0;
			func_q    <= '0;
		end else if (advance) begin
			count_q   <= count_d;
			silence_q <= silence_d;
			crc_q     <= crc_d;
			nz_q      <= nz_d;
			tx_q      <= tx_d;
			addr_q    <= addr_d;
			func_q    <= func_d;
		end
	end

	always_comb begin
		count_d   = count_q;
		silence_d = silence_q;
		crc_d     = crc_q;
		nz_d      = nz_q;
		tx_d      = tx_q;
		addr_d    = addr_q;
		func_d    = func_q;
		emit      = 1'b0;
		result    = '0;

		// A byte after a long gap starts a fresh frame.
		if (count_q != '0 && silence_q > cfg.gap_restart_ticks) begin
			cnt_base  = '0;
			crc_base  = CRC_PRESET;
			nz_base   = 1'b0;
			addr_base = '0;
			func_base = '0;
		end else begin
			cnt_base  = count_q;
			crc_base  = crc_q;
			nz_base   = nz_q;
			addr_base = addr_q;
			func_base = func_q;
		end
		cnt_next = cnt_base + CNT_W'(1);
		pos_ext  = {8'h00, cnt_base};
		pl_ext   = {8'h00, count_q} - (CNT_W + 8)'(MIN_FRAME);
		sil_inc  = (silence_q == SILENCE_MAX) ? silence_q : silence_q + 16'd1;

		case (item.kind)
			KIND_BYTE: begin
				if (!tx_q) begin
					if (item.line_errors != 4'h0) begin
						count_d   = '0;
						crc_d     = CRC_PRESET;
						nz_d      = 1'b0;
						addr_d    = '0;
						func_d    = '0;
						silence_d = '0;
					end else begin
						addr_d = (cnt_base == CNT_W'(0)) ? item.rx_byte : addr_base;
						func_d = (cnt_base == CNT_W'(1)) ? item.rx_byte : func_base;
						crc_d  = crc_fold(crc_base, item.rx_byte);
						nz_d   = nz_base | (item.rx_byte != 8'h00);
						silence_d = '0;
						emit   = 1'b1;
						result.result_kind   = RES_BYTE;
						result.byte_value    = item.rx_byte;
						result.byte_position = pos_ext[7:0];
						result.verdict       = VERDICT_OK;
						if (cnt_next >= CNT_W'(MAX_FRAME)) begin
							count_d = '0;
							crc_d   = CRC_PRESET;
							nz_d    = 1'b0;
							addr_d  = '0;
							func_d  = '0;
						end else begin
							count_d = cnt_next;
						end
					end
				end
			end
			KIND_TICK: begin
				silence_d = sil_inc;
				if (count_q != '0 && sil_inc >= cfg.frame_end_ticks) begin
					emit = 1'b1;
					result.result_kind = RES_VERDICT;
					if (!nz_q) begin
						result.verdict = VERDICT_NOISE;
					end else if (count_q < CNT_W'(MIN_FRAME)) begin
						result.verdict = VERDICT_SHORT;
					end else begin
						result.verdict = (crc_q == 16'h0000) ? VERDICT_OK : VERDICT_CRC_ERR;
						result.slave_address  = addr_q;
						result.func_code      = func_q;
						result.payload_length = (pl_ext > (CNT_W + 8)'(255)) ? 8'hFF
							: pl_ext[7:0];
					end
					count_d = '0;
					crc_d   = CRC_PRESET;
					nz_d    = 1'b0;
					addr_d  = '0;
					func_d  = '0;
				end
			end
			KIND_TX_BEGIN: begin
				tx_d    = 1'b1;
				count_d = '0;
				crc_d   = CRC_PRESET;
				nz_d    = 1'b0;
				addr_d  = '0;
				func_d  = '0;
			end
			KIND_TX_END: begin
				tx_d = 1'b0;
			end
			default: begin
				tx_d = tx_q;
			end
		endcase
	end

endmodule

[src/rtu_out_reg.sv]
// Result register that holds one word until the consumer takes it.
module rtu_out_reg
	import rtu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    emit,
	input  result_t result_in,
	input  logic    out_ready,
	output logic    out_valid,
	output logic    free,
	output result_t result_q
);

	logic valid_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= emit;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && emit) begin
			result_q <= result_in;
		end
	end

endmodule
